### src/fpff_pkg.sv
// Shared types, widths and codes for the flight phase and fault flag decoder.
// No dependencies; the design files refer to this package by scoped names, the bench imports it.
`default_nettype none

package fpff_pkg;

    // Field widths
    localparam int ALT_W      = 21;
    localparam int RATE_W     = 16;
    localparam int PRESS_W    = 18;
    localparam int LAT_W      = 31;
    localparam int LON_W      = 32;
    localparam int CMD_W      = 16;
    localparam int PHASE_W    = 3;
    localparam int FLAGS_W    = 6;
    localparam int APEX_W     = 20;
    localparam int SPEED_W    = 15;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_APEX_ALTITUDE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_SPEED_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_SPEED_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_SPEED_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_SPEED_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_LOW       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_HIGH      = 3'd6;

    // Register reset values
    localparam logic [APEX_W-1:0]  APEX_RESET          = 20'd40000;
    localparam logic [SPEED_W-1:0] MODEL_LOW_RESET     = 15'd1200;
    localparam logic [SPEED_W-1:0] MODEL_HIGH_RESET    = 15'd1400;
    localparam logic [SPEED_W-1:0] PAYLOAD_LOW_RESET   = 15'd600;
    localparam logic [SPEED_W-1:0] PAYLOAD_HIGH_RESET  = 15'd800;
    localparam logic [PRESS_W-1:0] PRESSURE_LOW_RESET  = 18'd50000;
    localparam logic [PRESS_W-1:0] PRESSURE_HIGH_RESET = 18'd120000;

    // Flight phase codes
    localparam logic [PHASE_W-1:0] PHASE_READY      = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_ASCENT     = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_MODEL_DESC = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_SEPARATION = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_PAYLOAD    = 3'd4;
    localparam logic [PHASE_W-1:0] PHASE_RECOVERY   = 3'd5;

    // Fault flag bit positions
    localparam int FLAG_MODEL_SPEED   = 0;
    localparam int FLAG_PAYLOAD_SPEED = 1;
    localparam int FLAG_PRESSURE      = 2;
    localparam int FLAG_GPS           = 3;
    localparam int FLAG_SEPARATION    = 4;
    localparam int FLAG_COMMAND       = 5;

    // Altitude thresholds in centimetres
    localparam int READY_ALT_LIMIT  = 500;
    localparam int READY_PEAK_LIMIT = 1000;
    localparam int LOW_BAND_LIMIT   = 5000;
    localparam int RECOVERY_LIMIT   = 1000;
    localparam int APEX_MARGIN      = 1000;

    typedef struct packed {
        logic [APEX_W-1:0]  apex_altitude;
        logic [SPEED_W-1:0] model_speed_low;
        logic [SPEED_W-1:0] model_speed_high;
        logic [SPEED_W-1:0] payload_speed_low;
        logic [SPEED_W-1:0] payload_speed_high;
        logic [PRESS_W-1:0] pressure_low;
        logic [PRESS_W-1:0] pressure_high;
    } cfg_t;

    typedef struct packed {
        logic signed [ALT_W-1:0]  main_altitude;
        logic signed [ALT_W-1:0]  second_altitude;
        logic signed [ALT_W-1:0]  earlier_altitude;
        logic signed [RATE_W-1:0] descent_rate;
        logic [PRESS_W-1:0]       carrier_pressure;
        logic signed [LAT_W-1:0]  latitude;
        logic signed [LON_W-1:0]  longitude;
        logic [CMD_W-1:0]         command_digits;
    } sample_t;

endpackage

`default_nettype wire

### src/fpff_cfg_regs.sv
// Configuration register file for the flight phase decoder.
// Depends on fpff_pkg for the index codes, reset values and cfg_t.
`default_nettype none

module fpff_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write_en,
    input  wire logic [fpff_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [fpff_pkg::CFG_DATA_W-1:0]    cfg_data,
    output fpff_pkg::cfg_t                          cfg
);

    fpff_pkg::cfg_t cfg_reg;
    fpff_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                fpff_pkg::REG_APEX_ALTITUDE:
                    cfg_next.apex_altitude = cfg_data[fpff_pkg::APEX_W-1:0];
                fpff_pkg::REG_MODEL_SPEED_LOW:
                    cfg_next.model_speed_low = cfg_data[fpff_pkg::SPEED_W-1:0];
                fpff_pkg::REG_MODEL_SPEED_HIGH:
                    cfg_next.model_speed_high = cfg_data[fpff_pkg::SPEED_W-1:0];
                fpff_pkg::REG_PAYLOAD_SPEED_LOW:
                    cfg_next.payload_speed_low = cfg_data[fpff_pkg::SPEED_W-1:0];
                fpff_pkg::REG_PAYLOAD_SPEED_HIGH:
                    cfg_next.payload_speed_high = cfg_data[fpff_pkg::SPEED_W-1:0];
                fpff_pkg::REG_PRESSURE_LOW:
                    cfg_next.pressure_low = cfg_data[fpff_pkg::PRESS_W-1:0];
                fpff_pkg::REG_PRESSURE_HIGH:
                    cfg_next.pressure_high = cfg_data[fpff_pkg::PRESS_W-1:0];
                default:
                    cfg_next = cfg_reg;   // unused index: drop the write
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.apex_altitude      <= fpff_pkg::APEX_RESET;
            cfg_reg.model_speed_low    <= fpff_pkg::MODEL_LOW_RESET;
            cfg_reg.model_speed_high   <= fpff_pkg::MODEL_HIGH_RESET;
            cfg_reg.payload_speed_low  <= fpff_pkg::PAYLOAD_LOW_RESET;
            cfg_reg.payload_speed_high <= fpff_pkg::PAYLOAD_HIGH_RESET;
            cfg_reg.pressure_low       <= fpff_pkg::PRESSURE_LOW_RESET;
            cfg_reg.pressure_high      <= fpff_pkg::PRESSURE_HIGH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### src/fpff_phase.sv
// Flight phase decision with the peak altitude and last phase state.
// Depends on fpff_pkg for sample_t, phase codes and altitude thresholds.
`default_nettype none

module fpff_phase (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire fpff_pkg::sample_t             sample,
    input  wire logic [fpff_pkg::APEX_W-1:0]   apex_altitude,
    output logic [fpff_pkg::PHASE_W-1:0]       phase
);

    logic signed [fpff_pkg::ALT_W-1:0]   peak_reg;
    logic signed [fpff_pkg::ALT_W-1:0]   peak_next;
    logic [fpff_pkg::PHASE_W-1:0]        last_phase_reg;

    // 22-bit signed view so the unsigned apex compares against altitudes
    logic signed [fpff_pkg::ALT_W:0]     alt_x;
    logic signed [fpff_pkg::ALT_W:0]     peak_x;
    logic signed [fpff_pkg::ALT_W:0]     apex_x;

    logic below_ready;
    logic peak_low;
    logic climbing;
    logic above_apex;
    logic above_low_band;
    logic peak_over_apex;
    logic in_recovery_band;
    logic last_sep_or_later;

    always_comb
    begin
        peak_next = (sample.main_altitude > peak_reg) ? sample.main_altitude : peak_reg;
    end

    assign alt_x  = {sample.main_altitude[fpff_pkg::ALT_W-1], sample.main_altitude};
    assign peak_x = {peak_next[fpff_pkg::ALT_W-1], peak_next};
    assign apex_x = $signed({2'b00, apex_altitude});

    assign below_ready      = alt_x < 22'(fpff_pkg::READY_ALT_LIMIT);
    assign peak_low         = peak_x < 22'(fpff_pkg::READY_PEAK_LIMIT);
    assign climbing         = (sample.main_altitude > sample.earlier_altitude)
                              && (sample.second_altitude > 21'(fpff_pkg::LOW_BAND_LIMIT));
    assign above_apex       = alt_x > apex_x;
    assign above_low_band   = alt_x > 22'(fpff_pkg::LOW_BAND_LIMIT);
    assign peak_over_apex   = peak_x > apex_x;
    assign in_recovery_band = alt_x <= 22'(fpff_pkg::RECOVERY_LIMIT);
    assign last_sep_or_later = last_phase_reg >= fpff_pkg::PHASE_SEPARATION;

    // First match wins; phase 4 in the low band falls back to ready
    always_comb
    begin
        phase = fpff_pkg::PHASE_READY;
        if (below_ready && peak_low)
        begin
            phase = fpff_pkg::PHASE_READY;
        end
        else if (climbing)
        begin
            phase = fpff_pkg::PHASE_ASCENT;
        end
        else if (above_apex && (last_phase_reg == fpff_pkg::PHASE_ASCENT))
        begin
            phase = fpff_pkg::PHASE_MODEL_DESC;
        end
        else if (!above_apex && above_low_band && peak_over_apex)
        begin
            phase = last_sep_or_later ? fpff_pkg::PHASE_SEPARATION
                                      : fpff_pkg::PHASE_MODEL_DESC;
        end
        else if (!above_low_band && peak_over_apex)
        begin
            case (last_phase_reg)
                fpff_pkg::PHASE_MODEL_DESC: phase = fpff_pkg::PHASE_SEPARATION;
                fpff_pkg::PHASE_SEPARATION: phase = fpff_pkg::PHASE_PAYLOAD;
                default:                    phase = fpff_pkg::PHASE_READY;
            endcase
        end
        else if (in_recovery_band && last_sep_or_later)
        begin
            phase = fpff_pkg::PHASE_RECOVERY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg       <= '0;
            last_phase_reg <= fpff_pkg::PHASE_READY;
        end
        else if (advance)
        begin
            peak_reg       <= peak_next;
            last_phase_reg <= phase;
        end
    end

endmodule

`default_nettype wire

### src/fpff_flags.sv
// Fault flag comparisons for one telemetry sample and its decided phase.
// Depends on fpff_pkg for sample_t, cfg_t, phase codes and flag positions.
`default_nettype none

module fpff_flags (
    input  wire fpff_pkg::sample_t             sample,
    input  wire fpff_pkg::cfg_t                cfg,
    input  wire logic [fpff_pkg::PHASE_W-1:0]  phase,
    output logic [fpff_pkg::FLAGS_W-1:0]       flags
);

    logic signed [fpff_pkg::RATE_W:0]   rate_x;
    logic signed [fpff_pkg::RATE_W:0]   model_low_x;
    logic signed [fpff_pkg::RATE_W:0]   model_high_x;
    logic signed [fpff_pkg::RATE_W:0]   payload_low_x;
    logic signed [fpff_pkg::RATE_W:0]   payload_high_x;
    logic signed [fpff_pkg::ALT_W+1:0]  alt_x;
    logic signed [fpff_pkg::ALT_W+1:0]  apex_x;
    logic signed [fpff_pkg::ALT_W+1:0]  sep_upper;
    logic signed [fpff_pkg::ALT_W+1:0]  sep_lower;

    assign rate_x         = {sample.descent_rate[fpff_pkg::RATE_W-1], sample.descent_rate};
    assign model_low_x    = $signed({2'b00, cfg.model_speed_low});
    assign model_high_x   = $signed({2'b00, cfg.model_speed_high});
    assign payload_low_x  = $signed({2'b00, cfg.payload_speed_low});
    assign payload_high_x = $signed({2'b00, cfg.payload_speed_high});

    assign alt_x     = {{2{sample.main_altitude[fpff_pkg::ALT_W-1]}}, sample.main_altitude};
    assign apex_x    = $signed({3'b000, cfg.apex_altitude});
    assign sep_upper = apex_x + 23'(fpff_pkg::APEX_MARGIN);
    assign sep_lower = apex_x - 23'(fpff_pkg::APEX_MARGIN);

    always_comb
    begin
        flags = '0;
        flags[fpff_pkg::FLAG_MODEL_SPEED] = (phase == fpff_pkg::PHASE_MODEL_DESC)
            && ((rate_x < model_low_x) || (rate_x > model_high_x));
        flags[fpff_pkg::FLAG_PAYLOAD_SPEED] = (phase == fpff_pkg::PHASE_PAYLOAD)
            && ((rate_x < payload_low_x) || (rate_x > payload_high_x));
        flags[fpff_pkg::FLAG_PRESSURE] = (sample.carrier_pressure < cfg.pressure_low)
            || (sample.carrier_pressure > cfg.pressure_high);
        flags[fpff_pkg::FLAG_GPS] = (sample.latitude == '0) && (sample.longitude == '0);
        flags[fpff_pkg::FLAG_SEPARATION] = (alt_x <= sep_upper) && (alt_x >= sep_lower)
            && (phase != fpff_pkg::PHASE_SEPARATION);
        flags[fpff_pkg::FLAG_COMMAND] = (sample.command_digits == '0)
            && (phase >= fpff_pkg::PHASE_SEPARATION);
    end

endmodule

`default_nettype wire

### src/flight_phase_and_fault_flags_top.sv
// Top level of the flight phase and fault flag decoder: request registers,
// result register and handshake. Depends on fpff_pkg, fpff_cfg_regs,
// fpff_phase and fpff_flags.
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+-----------------------------------
//  sample   | sample_valid / sample_stall     | eight telemetry fields
//  result   | result_valid / result_stall     | flight_phase, fault_flags
//  config   | cfg_write_en                    | cfg_index, cfg_data
//
// One request per cycle sustained while results are not stalled; a taken request
// passes the input register, then the result register, on its way to the outputs.
// The peak altitude and last phase update in the single cycle that moves a request
// into the result register.
// Reset loads the default register values and clears peak, last phase and valids.
// A stalled result holds; the sample side stalls only while both stages are full
// and the result is stalled.
`default_nettype none

module flight_phase_and_fault_flags_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               sample_valid,
    output logic                                    sample_stall,
    input  wire logic signed [fpff_pkg::ALT_W-1:0]  main_altitude,
    input  wire logic signed [fpff_pkg::ALT_W-1:0]  second_altitude,
    input  wire logic signed [fpff_pkg::ALT_W-1:0]  earlier_altitude,
    input  wire logic signed [fpff_pkg::RATE_W-1:0] descent_rate,
    input  wire logic [fpff_pkg::PRESS_W-1:0]       carrier_pressure,
    input  wire logic signed [fpff_pkg::LAT_W-1:0]  latitude,
    input  wire logic signed [fpff_pkg::LON_W-1:0]  longitude,
    input  wire logic [fpff_pkg::CMD_W-1:0]         command_digits,

    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output logic [fpff_pkg::PHASE_W-1:0]            flight_phase,
    output logic [fpff_pkg::FLAGS_W-1:0]            fault_flags,

    input  wire logic                               cfg_write_en,
    input  wire logic [fpff_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [fpff_pkg::CFG_DATA_W-1:0]    cfg_data
);

    fpff_pkg::cfg_t    cfg;
    fpff_pkg::sample_t sample_reg;

    logic                           sample_valid_reg;
    logic                           sample_valid_next;
    logic                           result_valid_reg;
    logic                           result_valid_next;
    logic [fpff_pkg::PHASE_W-1:0]   phase_reg;
    logic [fpff_pkg::FLAGS_W-1:0]   flags_reg;
    logic [fpff_pkg::PHASE_W-1:0]   phase_calc;
    logic [fpff_pkg::FLAGS_W-1:0]   flags_calc;
    logic                           advance;
    logic                           accept;

    fpff_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    fpff_phase u_phase (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .sample        (sample_reg),
        .apex_altitude (cfg.apex_altitude),
        .phase         (phase_calc)
    );

    fpff_flags u_flags (
        .sample (sample_reg),
        .cfg    (cfg),
        .phase  (phase_calc),
        .flags  (flags_calc)
    );

    // Move the held request on whenever the result register is free or draining
    assign advance      = sample_valid_reg && (!result_valid_reg || !result_stall);
    assign sample_stall = sample_valid_reg && !advance;
    assign accept       = sample_valid && !sample_stall;

    always_comb
    begin
        sample_valid_next = sample_valid_reg;
        if (accept)
        begin
            sample_valid_next = 1'b1;
        end
        else if (advance)
        begin
            sample_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            sample_valid_reg <= sample_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg.main_altitude    <= main_altitude;
            sample_reg.second_altitude  <= second_altitude;
            sample_reg.earlier_altitude <= earlier_altitude;
            sample_reg.descent_rate     <= descent_rate;
            sample_reg.carrier_pressure <= carrier_pressure;
            sample_reg.latitude         <= latitude;
            sample_reg.longitude        <= longitude;
            sample_reg.command_digits   <= command_digits;
        end
        if (advance)
        begin
            phase_reg <= phase_calc;
            flags_reg <= flags_calc;
        end
    end

    assign result_valid = result_valid_reg;
    assign flight_phase = phase_reg;
    assign fault_flags  = flags_reg;

    // The phase code never leaves the defined range
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (flight_phase <= fpff_pkg::PHASE_RECOVERY))
        else $error("flight phase out of range");

    // Speed window flags only appear in their own descent phase
    a_speed_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (!fault_flags[fpff_pkg::FLAG_MODEL_SPEED]
                || (flight_phase == fpff_pkg::PHASE_MODEL_DESC))
            && (!fault_flags[fpff_pkg::FLAG_PAYLOAD_SPEED]
                || (flight_phase == fpff_pkg::PHASE_PAYLOAD)))
        else $error("speed flag raised outside its phase");

    // Separation flag is never paired with the separation phase
    a_sep_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(fault_flags[fpff_pkg::FLAG_SEPARATION]
            && (flight_phase == fpff_pkg::PHASE_SEPARATION)))
        else $error("separation flag during separation phase");

    // The sample side only stalls behind a stalled, full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (result_valid && result_stall))
        else $error("sample stalled without a stalled result");

    // A request moved on while the result was stalled would overwrite it
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> $stable(flight_phase) && $stable(fault_flags))
        else $error("stalled result overwritten");

endmodule

`default_nettype wire

### tb/sv/flight_phase_and_fault_flags_top_test.sv
// Self-checking bench for the flight phase and fault flag decoder: queued telemetry
// requests go through the valid/stall channels and every result is checked in order.
// Depends on fpff_pkg and flight_phase_and_fault_flags_top.
`default_nettype none

module flight_phase_and_fault_flags_top_test;
    import fpff_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int SETTLE_CYCLES   = 4;
    localparam int ITEMS_PER_PHASE = 85;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [FLAGS_W-1:0] flags;
    } status_t;

    logic                      clk              = 1'b0;
    logic                      rst_n            = 1'b0;
    logic                      sample_valid     = 1'b0;
    logic                      sample_stall;
    logic signed [ALT_W-1:0]   main_altitude    = '0;
    logic signed [ALT_W-1:0]   second_altitude  = '0;
    logic signed [ALT_W-1:0]   earlier_altitude = '0;
    logic signed [RATE_W-1:0]  descent_rate     = '0;
    logic [PRESS_W-1:0]        carrier_pressure = '0;
    logic signed [LAT_W-1:0]   latitude         = '0;
    logic signed [LON_W-1:0]   longitude        = '0;
    logic [CMD_W-1:0]          command_digits   = '0;
    logic                      result_valid;
    logic                      result_stall     = 1'b0;
    logic [PHASE_W-1:0]        flight_phase;
    logic [FLAGS_W-1:0]        fault_flags;
    logic                      cfg_write_en     = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index        = '0;
    logic [CFG_DATA_W-1:0]     cfg_data         = '0;

    // shadow of the block's registers and state
    cfg_t               shadow_cfg;
    logic [PHASE_W-1:0] prior_phase;
    int                 peak_seen;

    sample_t telemetry_backlog[$];
    status_t expected_status[$];

    int unsigned queued_count   = 0;
    int unsigned offered_count  = 0;
    int unsigned taken_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    bit calm         = 1'b0;
    bit hold_request = 1'b0;
    int idle_odds    = 4;
    int send_gap     = 0;
    int recv_gap     = 0;
    int hold_left    = 0;

    flight_phase_and_fault_flags_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample_valid     (sample_valid),
        .sample_stall     (sample_stall),
        .main_altitude    (main_altitude),
        .second_altitude  (second_altitude),
        .earlier_altitude (earlier_altitude),
        .descent_rate     (descent_rate),
        .carrier_pressure (carrier_pressure),
        .latitude         (latitude),
        .longitude        (longitude),
        .command_digits   (command_digits),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .flight_phase     (flight_phase),
        .fault_flags      (fault_flags),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Phase and flags for one request; advances the shadow peak and last phase.
    function automatic status_t decode_telemetry(input sample_t s);
        status_t            r;
        int                 alt;
        int                 alt2;
        int                 prev;
        int                 rate;
        int                 apex;
        int                 press;
        logic [PHASE_W-1:0] phase;
        logic [FLAGS_W-1:0] flags;
        alt   = int'(s.main_altitude);
        alt2  = int'(s.second_altitude);
        prev  = int'(s.earlier_altitude);
        rate  = int'(s.descent_rate);
        apex  = int'(shadow_cfg.apex_altitude);
        press = int'(s.carrier_pressure);

        if (alt > peak_seen)
            peak_seen = alt;

        if (alt < READY_ALT_LIMIT && peak_seen < READY_PEAK_LIMIT)
            phase = PHASE_READY;
        else if (alt > prev && alt2 > LOW_BAND_LIMIT)
            phase = PHASE_ASCENT;
        else if (alt > apex && prior_phase == PHASE_ASCENT)
            phase = PHASE_MODEL_DESC;
        else if (alt <= apex && alt > LOW_BAND_LIMIT && peak_seen > apex)
            phase = (prior_phase <= PHASE_MODEL_DESC) ? PHASE_MODEL_DESC : PHASE_SEPARATION;
        else if (alt <= LOW_BAND_LIMIT && peak_seen > apex)
        begin
            // payload descent drops back to ready here, not to recovery
            if (prior_phase == PHASE_MODEL_DESC)
                phase = PHASE_SEPARATION;
            else if (prior_phase == PHASE_SEPARATION)
                phase = PHASE_PAYLOAD;
            else
                phase = PHASE_READY;
        end
        else if (alt <= RECOVERY_LIMIT && prior_phase >= PHASE_SEPARATION)
            phase = PHASE_RECOVERY;
        else
            phase = PHASE_READY;
        prior_phase = phase;

        flags = '0;
        if (phase == PHASE_MODEL_DESC && (rate < int'(shadow_cfg.model_speed_low) ||
                                          rate > int'(shadow_cfg.model_speed_high)))
            flags[FLAG_MODEL_SPEED] = 1'b1;
        if (phase == PHASE_PAYLOAD && (rate < int'(shadow_cfg.payload_speed_low) ||
                                       rate > int'(shadow_cfg.payload_speed_high)))
            flags[FLAG_PAYLOAD_SPEED] = 1'b1;
        if (press < int'(shadow_cfg.pressure_low) || press > int'(shadow_cfg.pressure_high))
            flags[FLAG_PRESSURE] = 1'b1;
        if (s.latitude == 0 && s.longitude == 0)
            flags[FLAG_GPS] = 1'b1;
        if (alt <= apex + APEX_MARGIN && alt >= apex - APEX_MARGIN && phase != PHASE_SEPARATION)
            flags[FLAG_SEPARATION] = 1'b1;
        if (s.command_digits == 0 && phase >= PHASE_SEPARATION)
            flags[FLAG_COMMAND] = 1'b1;

        r.phase = phase;
        r.flags = flags;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic int pick(input longint lo, input longint hi);
        return int'(lo + longint'($urandom_range(0, 32'(hi - lo))));
    endfunction

    // Speeds on and around the edges of a window, with some anywhere.
    function automatic int speed_near(input int lo, input int hi);
        case ($urandom_range(0, 6))
            0: return lo - 1;
            1: return lo;
            2: return hi;
            3: return hi + 1;
            4: return int'($signed(16'($urandom)));
            default: return pick(lo < hi ? lo : hi, lo < hi ? hi : lo);
        endcase
    endfunction

    function automatic sample_t telemetry(input int alt, input int alt2, input int earlier,
                                          input int rate, input int press, input longint lat,
                                          input longint lon, input int cmd);
        sample_t s;
        s.main_altitude    = 21'(alt);
        s.second_altitude  = 21'(alt2);
        s.earlier_altitude = 21'(earlier);
        s.descent_rate     = 16'(rate);
        s.carrier_pressure = 18'(press);
        s.latitude         = 31'(lat);
        s.longitude        = 32'(lon);
        s.command_digits   = 16'(cmd);
        return s;
    endfunction

    function automatic sample_t flight_sample(input int alt, input int earlier);
        sample_t s;
        s.main_altitude    = 21'(alt);
        s.earlier_altitude = 21'(($urandom_range(0, 11) == 0) ? pick(-100000, 1000000)
                                                               : earlier);
        s.second_altitude  = 21'(($urandom_range(0, 9) == 0) ? pick(-100000, 1000000)
                                                              : alt + pick(-3000, 3000));
        if ($urandom_range(0, 1) == 1)
            s.descent_rate = 16'(speed_near(int'(shadow_cfg.model_speed_low),
                                            int'(shadow_cfg.model_speed_high)));
        else
            s.descent_rate = 16'(speed_near(int'(shadow_cfg.payload_speed_low),
                                            int'(shadow_cfg.payload_speed_high)));
        case ($urandom_range(0, 5))
            0: s.carrier_pressure = shadow_cfg.pressure_low - 1'b1;
            1: s.carrier_pressure = shadow_cfg.pressure_low;
            2: s.carrier_pressure = shadow_cfg.pressure_high;
            3: s.carrier_pressure = shadow_cfg.pressure_high + 1'b1;
            default: s.carrier_pressure = 18'(pick(0, 200000));
        endcase
        s.latitude  = 31'(pick(-900000000, 900000000));
        s.longitude = 32'(pick(-1800000000, 1800000000));
        case ($urandom_range(0, 7))
            0:
            begin
                s.latitude  = '0;
                s.longitude = '0;
            end
            1: s.latitude  = '0;
            2: s.longitude = '0;
            default: ;
        endcase
        s.command_digits = 16'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535));
        return s;
    endfunction

    task automatic enqueue(input sample_t s);
        telemetry_backlog.push_back(s);
        queued_count++;
    endtask

    // Whole flights with random content, broken now and then by raw noise.
    task automatic queue_flights(input int count);
        int      goal;
        int      apex;
        int      summit;
        int      climb;
        int      fall;
        int      alt;
        int      earlier;
        sample_t s;
        goal = queued_count + count;
        while (queued_count < goal)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    s.main_altitude    = 21'($urandom);
                    s.second_altitude  = 21'($urandom);
                    s.earlier_altitude = 21'($urandom);
                    s.descent_rate     = 16'($urandom);
                    s.carrier_pressure = 18'($urandom);
                    s.latitude         = 31'($urandom);
                    s.longitude        = 32'($urandom);
                    s.command_digits   = 16'(($urandom_range(0, 2) == 0) ? 0 : $urandom);
                    enqueue(s);
                end
            end
            else
            begin
                apex   = int'(shadow_cfg.apex_altitude);
                summit = apex + pick(1000, 60000);
                if (summit > 1000000)
                    summit = 1000000;
                alt     = pick(-300, 400);
                earlier = alt;
                repeat ($urandom_range(1, 3))
                begin
                    enqueue(flight_sample(alt, earlier));
                    earlier = alt;
                    alt     = pick(-300, 400);
                end
                climb = summit / pick(4, 10) + 500;
                while (alt < summit)
                begin
                    alt += pick(climb / 2, climb);
                    if (alt > summit)
                        alt = summit;
                    enqueue(flight_sample(alt, earlier));
                    earlier = alt;
                end
                fall = summit / pick(5, 12) + 300;
                while (alt > 0)
                begin
                    // skim the band around the separation altitude now and then
                    if ($urandom_range(0, 5) == 0)
                        alt = apex + pick(-1200, 1200);
                    else
                        alt -= pick(fall / 2, fall);
                    if (alt < 0)
                        alt = pick(-400, 1000);
                    enqueue(flight_sample(alt, earlier));
                    earlier = alt;
                end
                repeat ($urandom_range(1, 3))
                begin
                    alt = pick(-300, 1000);
                    enqueue(flight_sample(alt, earlier));
                    earlier = alt;
                end
            end
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input int value);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= index;
        cfg_data     <= data;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        case (index)
            REG_APEX_ALTITUDE:      shadow_cfg.apex_altitude      = data[APEX_W-1:0];
            REG_MODEL_SPEED_LOW:    shadow_cfg.model_speed_low    = data[SPEED_W-1:0];
            REG_MODEL_SPEED_HIGH:   shadow_cfg.model_speed_high   = data[SPEED_W-1:0];
            REG_PAYLOAD_SPEED_LOW:  shadow_cfg.payload_speed_low  = data[SPEED_W-1:0];
            REG_PAYLOAD_SPEED_HIGH: shadow_cfg.payload_speed_high = data[SPEED_W-1:0];
            REG_PRESSURE_LOW:       shadow_cfg.pressure_low       = data[PRESS_W-1:0];
            REG_PRESSURE_HIGH:      shadow_cfg.pressure_high      = data[PRESS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int apex, input int model_low, input int model_high,
                                 input int payload_low, input int payload_high,
                                 input int press_low, input int press_high);
        write_register(REG_APEX_ALTITUDE, apex);
        write_register(REG_MODEL_SPEED_LOW, model_low);
        write_register(REG_MODEL_SPEED_HIGH, model_high);
        write_register(REG_PAYLOAD_SPEED_LOW, payload_low);
        write_register(REG_PAYLOAD_SPEED_HIGH, payload_high);
        write_register(REG_PRESSURE_LOW, press_low);
        write_register(REG_PRESSURE_HIGH, press_high);
    endtask

    // Hold until every request has gone through and every result has come back.
    task automatic settle();
        while (telemetry_backlog.size() != 0 || taken_count != offered_count ||
               expected_status.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Sender: offer the next request once the current one is taken.
    always @(negedge clk)
    begin : sender
        sample_t item;
        if (!rst_n)
            sample_valid <= 1'b0;
        else if (taken_count == offered_count)
        begin
            if (send_gap == 0 && !calm && $urandom_range(0, 15) < idle_odds)
                send_gap = $urandom_range(1, 13);
            if (send_gap != 0)
            begin
                send_gap--;
                sample_valid <= 1'b0;
            end
            else if (telemetry_backlog.size() != 0)
            begin
                item = telemetry_backlog.pop_front();
                {main_altitude, second_altitude, earlier_altitude, descent_rate,
                 carrier_pressure, latitude, longitude, command_digits} <= item;
                sample_valid <= 1'b1;
                offered_count++;
            end
            else
                sample_valid <= 1'b0;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_OFF_CYCLES - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            if (recv_gap == 0 && !calm && $urandom_range(0, 15) < idle_odds)
                recv_gap = $urandom_range(1, 13);
            if (recv_gap != 0)
            begin
                recv_gap--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : monitor
        status_t want;
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
            begin
                expected_status.push_back(decode_telemetry(
                    {main_altitude, second_altitude, earlier_altitude, descent_rate,
                     carrier_pressure, latitude, longitude, command_digits}));
                taken_count++;
            end
            if (result_valid && !result_stall)
            begin
                if (expected_status.size() == 0)
                    report_mismatch($sformatf("result with nothing pending: phase %0d flags %b",
                                              flight_phase, fault_flags));
                else
                begin
                    want = expected_status.pop_front();
                    if (flight_phase !== want.phase)
                        report_mismatch($sformatf("flight_phase %0d, want %0d",
                                                  flight_phase, want.phase));
                    if (fault_flags !== want.flags)
                        report_mismatch($sformatf("fault_flags %b, want %b",
                                                  fault_flags, want.flags));
                end
            end
        end
    end

    initial
    begin : scenario
        int model_low;
        int payload_low;
        int press_low;
        shadow_cfg  = {APEX_RESET, MODEL_LOW_RESET, MODEL_HIGH_RESET, PAYLOAD_LOW_RESET,
                       PAYLOAD_HIGH_RESET, PRESSURE_LOW_RESET, PRESSURE_HIGH_RESET};
        prior_phase = PHASE_READY;
        peak_seen   = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // on the pad: ready wins over ascent while the peak is low
        enqueue(telemetry(0, 0, 0, 0, 0, 0, 0, 0));
        enqueue(telemetry(499, 6000, 0, -32768, 0, -900000000, 1800000000, 'h9999));
        enqueue(telemetry(-100000, -100000, 1000000, 32767, 200000, 900000000, -1800000000,
                          'hFFFF));
        // ascent past the apex, model descent, separation, payload descent
        enqueue(telemetry(6000, 6000, 0, 1300, 101325, 1, 1, 'h0001));
        enqueue(telemetry(39500, 40000, 6000, 1300, 101325, 1, 1, 'h1234));
        enqueue(telemetry(45000, 45000, 50000, 1199, 101325, 1, 0, 'h1234));
        enqueue(telemetry(41000, 41000, 45000, 1300, 101325, 0, 1, 'h1234));
        enqueue(telemetry(30000, 30000, 41000, 1400, 49999, 1, 1, 'h1234));
        enqueue(telemetry(20000, 20000, 30000, 1401, 120001, 1, 1, 'h1234));
        enqueue(telemetry(5000, 5000, 20000, 1300, 50000, 1, 1, 0));
        enqueue(telemetry(20000, 20000, 30000, 700, 120000, 1, 1, 0));
        enqueue(telemetry(4000, 4000, 20000, 599, 101325, 1, 1, 0));
        // payload descent at low altitude falls back to ready
        enqueue(telemetry(3000, 3000, 4000, 801, 101325, 1, 1, 'h0042));
        enqueue(telemetry(3000, 3000, 3000, 700, 101325, 1, 1, 0));
        enqueue(telemetry(2000, 6000, 0, 700, 101325, 1, 1, 'h0042));
        // full-width values beyond the documented ranges
        enqueue(telemetry(1048575, 1048575, -1048576, -32768, 262143, 1073741823,
                          2147483647, 'hABCD));
        enqueue(telemetry(-1048576, -1048576, 0, -1, 0, -1073741824, 32'h8000_0000, 0));
        settle();

        // inverted windows flag every value
        apply_setting(30000, 1400, 1200, 800, 600, 120000, 50000);
        enqueue(telemetry(20000, 20000, 25000, 1300, 80000, 1, 1, 'h0007));
        enqueue(telemetry(4000, 4000, 20000, 1300, 80000, 1, 1, 'h0007));
        enqueue(telemetry(3000, 3000, 4000, 700, 80000, 1, 1, 0));
        settle();

        // apex at or above the peak opens the recovery branch
        write_register(REG_APEX_ALTITUDE, 20'hFFFFF);
        enqueue(telemetry(800, 800, 900, 700, 80000, 1, 1, 0));
        enqueue(telemetry(1000, 1000, 2000, 700, 80000, 1, 1, 'h0010));
        enqueue(telemetry(1001, 1001, 2000, 700, 80000, 1, 1, 0));
        settle();

        // default windows; the receiver holds off so the block backs up
        apply_setting(APEX_RESET, MODEL_LOW_RESET, MODEL_HIGH_RESET, PAYLOAD_LOW_RESET,
                      PAYLOAD_HIGH_RESET, PRESSURE_LOW_RESET, PRESSURE_HIGH_RESET);
        queue_flights(ITEMS_PER_PHASE);
        hold_request = 1'b1;
        settle();

        apply_setting(0, 0, 0, 0, 0, 0, 0);
        idle_odds = 6;
        queue_flights(ITEMS_PER_PHASE);
        settle();

        // no idling on either side for this stretch
        apply_setting(1000000, 25500, 25500, 25500, 25500, 200000, 200000);
        idle_odds = 0;
        queue_flights(ITEMS_PER_PHASE);
        settle();

        apply_setting(20'hFFFFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 18'h3FFFF, 18'h3FFFF);
        idle_odds = 3;
        queue_flights(ITEMS_PER_PHASE);
        settle();

        model_low   = pick(1000, 25500);
        payload_low = pick(1000, 25500);
        press_low   = pick(1000, 200000);
        apply_setting(pick(0, 1000000), model_low, model_low - pick(1, 1000), payload_low,
                      payload_low - pick(1, 1000), press_low, press_low - pick(1, 1000));
        idle_odds = 8;
        queue_flights(ITEMS_PER_PHASE);
        settle();

        model_low   = pick(0, 20000);
        payload_low = pick(0, 20000);
        press_low   = pick(0, 150000);
        apply_setting(pick(0, 1000000), model_low, model_low + pick(0, 5000), payload_low,
                      payload_low + pick(0, 5000), press_low, press_low + pick(0, 50000));
        calm = 1'b1;
        queue_flights(ITEMS_PER_PHASE);
        settle();

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

### flight_phase_and_fault_flags_top.f
src/fpff_pkg.sv
src/fpff_cfg_regs.sv
src/fpff_phase.sv
src/fpff_flags.sv
src/flight_phase_and_fault_flags_top.sv
tb/sv/flight_phase_and_fault_flags_top_test.sv
